// ===== sv/serial_command_byte_parser_defines.svh =====
// ============================================================================
// Serial command byte parser assertion macros
// Concurrent check macros shared by the parser modules. Each one samples on
// the rising edge of clk and is disabled while rst_n is low.
// ============================================================================
`ifndef SERIAL_COMMAND_BYTE_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_BYTE_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

// The condition holds at every sampled edge.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/scp_pkg.sv =====
// ============================================================================
// Serial command byte parser package
// Types, character codes and reset values shared by the parser modules.
// ============================================================================
package scp_pkg;

    localparam logic [15:0] DEFAULT_PERIOD  = 16'd1000;
    localparam logic [2:0]  RESET_MODE      = 3'd0;
    localparam logic [15:0] MIN_PERIOD_RST  = 16'd10;
    localparam logic [15:0] MAX_PERIOD_RST  = 16'd10000;
    localparam logic [2:0]  MODE_LAST       = 3'd5;

    // ASCII codes recognised by the command decoder.
    localparam logic [7:0] CHR_T_UP = 8'h54;
    localparam logic [7:0] CHR_T_LO = 8'h74;
    localparam logic [7:0] CHR_L_UP = 8'h4C;
    localparam logic [7:0] CHR_L_LO = 8'h6C;
    localparam logic [7:0] CHR_M_UP = 8'h4D;
    localparam logic [7:0] CHR_M_LO = 8'h6D;
    localparam logic [7:0] CHR_0    = 8'h30;
    localparam logic [7:0] CHR_1    = 8'h31;
    localparam logic [7:0] CHR_5    = 8'h35;
    localparam logic [7:0] CHR_9    = 8'h39;
    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_SP   = 8'h20;

    typedef enum logic [1:0] {
        LETTER_IDLE,
        LETTER_T,
        LETTER_L,
        LETTER_M
    } letter_t;

    typedef enum logic {
        FUNC_BYTE,
        FUNC_TAKE
    } func_t;

    typedef enum logic {
        ACK_PERIOD,
        ACK_MODE
    } ack_kind_t;

    typedef enum logic [0:0] {
        CFG_MIN_PERIOD,
        CFG_MAX_PERIOD
    } cfg_idx_t;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
        logic [1:0] ack_source;
    } item_t;

    typedef struct packed {
        logic [15:0] report_period;
        logic [2:0]  control_mode;
        logic        led_on;
        logic        ack_valid;
        logic [1:0]  ack_ports;
        logic        ack_kind;
        logic [15:0] ack_value;
    } result_t;

    // Handshake status of the input register as seen by the top level.
    typedef struct packed {
        logic full;
        logic stall;
    } stage_status_t;

endpackage

// ===== sv/scp_in_stage.sv =====
// ============================================================================
// Serial command byte parser input register
// Captures one transfer from the input channel and holds it until the
// command core consumes it.
// ============================================================================
module scp_in_stage
    import scp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  item_t         in_item,
    input  logic          advance,
    output stage_status_t status,
    output item_t         item
);

    logic  full_reg;
    logic  full_next;
    logic  accept;
    item_t item_reg;

    // The register frees up in the same cycle as its item is consumed.
    assign status.full  = full_reg;
    assign status.stall = full_reg && !advance;
    assign accept       = in_valid && !status.stall;
    assign full_next    = accept || (full_reg && !advance);
    assign item         = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/scp_cmd_core.sv =====
// ============================================================================
// Serial command byte parser command core
// Holds the parser state and configuration and works out the state after
// one item, together with the result it produces, combinationally.
// ============================================================================
`include "serial_command_byte_parser_defines.svh"

module scp_cmd_core
    import scp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        fire,
    input  item_t       item,
    output result_t     result
);

    logic [15:0] min_period_reg;
    logic [15:0] max_period_reg;
    letter_t     letter_reg;
    letter_t     letter_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [15:0] period_reg;
    logic [15:0] period_next;
    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;
    logic        led_reg;
    logic        led_next;
    logic        ack_pending_reg;
    logic        ack_pending_next;
    logic [1:0]  ack_mask_reg;
    logic [1:0]  ack_mask_next;
    ack_kind_t   ack_kind_reg;
    ack_kind_t   ack_kind_next;
    logic [15:0] ack_value_reg;
    logic [15:0] ack_value_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] acc_prod;
    logic        acc_ovf;
    logic [31:0] acc_dig;
    logic [15:0] period_clamp;

    // acc * 10 + digit as acc * 8 + acc * 2 + digit; any bit above 31 means
    // the decimal value no longer fits.
    assign is_digit = (item.data >= CHR_0) && (item.data <= CHR_9);
    assign digit    = item.data[3:0];
    assign acc_prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {32'd0, digit};
    assign acc_ovf  = |acc_prod[35:32];
    assign acc_dig  = acc_ovf ? {16'd0, max_period_reg} : acc_prod[31:0];

    always_comb
    begin
        priority if (acc_dig < {16'd0, min_period_reg})
        begin
            period_clamp = min_period_reg;
        end
        else if (acc_dig > {16'd0, max_period_reg})
        begin
            period_clamp = max_period_reg;
        end
        else
        begin
            period_clamp = acc_dig[15:0];
        end
    end

    always_comb
    begin
        letter_next      = letter_reg;
        acc_next         = acc_reg;
        period_next      = period_reg;
        mode_next        = mode_reg;
        led_next         = led_reg;
        ack_pending_next = ack_pending_reg;
        ack_mask_next    = ack_mask_reg;
        ack_kind_next    = ack_kind_reg;
        ack_value_next   = ack_value_reg;
        result.ack_valid = 1'b0;
        result.ack_ports = 2'd0;
        result.ack_kind  = 1'b0;
        result.ack_value = 16'd0;

        priority if (func_t'(item.func) == FUNC_TAKE)
        begin
            if (ack_pending_reg)
            begin
                result.ack_valid = 1'b1;
                result.ack_ports = ack_mask_reg;
                result.ack_kind  = logic'(ack_kind_reg);
                result.ack_value = ack_value_reg;
                ack_pending_next = 1'b0;
                ack_mask_next    = 2'd0;
            end
        end
        else if ((item.data == CHR_T_UP) || (item.data == CHR_T_LO))
        begin
            letter_next = LETTER_T;
            acc_next    = 32'd0;
        end
        else if ((letter_reg == LETTER_T) && is_digit)
        begin
            acc_next         = acc_dig;
            period_next      = period_clamp;
            ack_mask_next    = ack_mask_reg | item.ack_source;
            ack_kind_next    = ACK_PERIOD;
            ack_value_next   = period_clamp;
            ack_pending_next = 1'b1;
        end
        else if ((item.data == CHR_L_UP) || (item.data == CHR_L_LO))
        begin
            letter_next = LETTER_L;
        end
        else if ((letter_reg == LETTER_L) && ((item.data == CHR_0) || (item.data == CHR_1)))
        begin
            led_next    = (item.data == CHR_1);
            letter_next = LETTER_IDLE;
        end
        else if ((item.data == CHR_M_UP) || (item.data == CHR_M_LO))
        begin
            letter_next = LETTER_M;
        end
        else if ((letter_reg == LETTER_M) && (item.data >= CHR_0) && (item.data <= CHR_5))
        begin
            mode_next        = item.data[2:0];
            ack_mask_next    = ack_mask_reg | item.ack_source;
            ack_kind_next    = ACK_MODE;
            ack_value_next   = {13'd0, item.data[2:0]};
            ack_pending_next = 1'b1;
            letter_next      = LETTER_IDLE;
        end
        else if ((item.data == CHR_CR) || (item.data == CHR_LF) || (item.data == CHR_SP))
        begin
            letter_next = LETTER_IDLE;
        end

        result.report_period = period_next;
        result.control_mode  = mode_next;
        result.led_on        = led_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= MIN_PERIOD_RST;
            max_period_reg <= MAX_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_PERIOD: min_period_reg <= cfg_data;
                CFG_MAX_PERIOD: max_period_reg <= cfg_data;
                default:        min_period_reg <= min_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_reg      <= LETTER_IDLE;
            acc_reg         <= 32'd0;
            period_reg      <= DEFAULT_PERIOD;
            mode_reg        <= RESET_MODE;
            led_reg         <= 1'b0;
            ack_pending_reg <= 1'b0;
            ack_mask_reg    <= 2'd0;
            ack_kind_reg    <= ACK_PERIOD;
            ack_value_reg   <= 16'd0;
        end
        else if (fire)
        begin
            letter_reg      <= letter_next;
            acc_reg         <= acc_next;
            period_reg      <= period_next;
            mode_reg        <= mode_next;
            led_reg         <= led_next;
            ack_pending_reg <= ack_pending_next;
            ack_mask_reg    <= ack_mask_next;
            ack_kind_reg    <= ack_kind_next;
            ack_value_reg   <= ack_value_next;
        end
    end

    // A take always leaves nothing pending, and the port mask only
    // accumulates while an acknowledge is pending.
    `ASSERT_NEXT(a_take_clears_pending, fire && (func_t'(item.func) == FUNC_TAKE), !ack_pending_reg)
    `ASSERT_IMPL(a_mask_needs_pending, !ack_pending_reg, ack_mask_reg == 2'd0)
    `ASSERT_ALWAYS(a_mode_in_range, mode_reg <= MODE_LAST)

endmodule

// ===== sv/serial_command_byte_parser.sv =====
// ============================================================================
// Serial command byte parser
// Decodes single-letter serial commands byte by byte and keeps the report
// period, control mode, indicator flag and pending acknowledge.
// ============================================================================
//
//  Channel   Handshake            Payload
//  -------   ------------------   -----------------------------------------
//  in        in_valid / in_stall  func, data, ack_source
//  out       out_valid/out_stall  report_period, control_mode, led_on,
//                                 ack_valid, ack_ports, ack_kind, ack_value
//  cfg       cfg_we               cfg_index, cfg_data (no read-back)
//
// One item is taken every cycle while out_stall is low; its result is presented
// once it has moved from the input register into the result register, and
// leaves from there when out_stall is low. This rate rests on the
// combinational update of the parser state in the command core, which
// each item reads and writes before the next one.
// Reset is asynchronous and active low; there is no clearing pass, and the
// block takes items as soon as reset is released.
// A stall on the output holds the result register; the input register still
// takes one more transfer, after which in_stall rises until the output moves.
//
`include "serial_command_byte_parser_defines.svh"

module serial_command_byte_parser
    import scp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  data,
    input  logic [1:0]  ack_source,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] report_period,
    output logic [2:0]  control_mode,
    output logic        led_on,
    output logic        ack_valid,
    output logic [1:0]  ack_ports,
    output logic        ack_kind,
    output logic [15:0] ack_value
);

    item_t         in_item;
    item_t         held_item;
    stage_status_t stage_status;
    logic          proc_fire;
    result_t       core_result;
    result_t       result_reg;
    logic          out_valid_reg;
    logic          out_valid_next;

    assign in_item.func       = func;
    assign in_item.data       = data;
    assign in_item.ack_source = ack_source;

    // The held item is processed whenever the result register is empty or
    // its current contents leave in this cycle.
    assign proc_fire = stage_status.full && (!out_valid_reg || !out_stall);
    assign in_stall  = stage_status.stall;

    scp_in_stage u_in_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_item (in_item),
        .advance (proc_fire),
        .status  (stage_status),
        .item    (held_item)
    );

    scp_cmd_core u_cmd_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .fire     (proc_fire),
        .item     (held_item),
        .result   (core_result)
    );

    // Result register: filled by each processed item, emptied by a transfer.
    assign out_valid_next = proc_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign report_period = result_reg.report_period;
    assign control_mode  = result_reg.control_mode;
    assign led_on        = result_reg.led_on;
    assign ack_valid     = result_reg.ack_valid;
    assign ack_ports     = result_reg.ack_ports;
    assign ack_kind      = result_reg.ack_kind;
    assign ack_value     = result_reg.ack_value;

    // Every processed item must land in the result register, and the input
    // side may only push back while it actually holds an item.
    `ASSERT_NEXT(a_fire_fills_result, proc_fire, out_valid_reg)
    `ASSERT_IMPL(a_stall_needs_item, in_stall, stage_status.full)

endmodule
